/* hdl/acgu_pkg.sv */
// Package for the adaptive congestion gain update block.
// Holds the field widths, the configuration register indexes and their reset values.
// No dependencies.
`timescale 1ns / 1ps

package acgu_pkg;

    localparam int RATIO_W   = 16;
    localparam int GAIN_W    = 24;
    localparam int GMIN_W    = 25;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CBR_TARGET = 3'd0,
        CFG_BETA_GAIN  = 3'd1,
        CFG_ALPHA_GAIN = 3'd2,
        CFG_GAIN_MAX   = 3'd3,
        CFG_GAIN_MIN   = 3'd4,
        CFG_DELTA_MAX  = 3'd5,
        CFG_DELTA_MIN  = 3'd6
    } cfg_index_t;

    localparam logic [RATIO_W-1:0] CBR_TARGET_RST = 16'd44564;
    localparam logic [GAIN_W-1:0]  BETA_GAIN_RST  = 24'd20133;
    localparam logic [GAIN_W-1:0]  ALPHA_GAIN_RST = 24'd268435;
    localparam logic [GAIN_W-1:0]  GAIN_MAX_RST   = 24'd8389;
    localparam logic [GMIN_W-1:0]  GAIN_MIN_RST   = -25'sd4194;
    localparam logic [GAIN_W-1:0]  DELTA_MAX_RST  = 24'd503316;
    localparam logic [GAIN_W-1:0]  DELTA_MIN_RST  = 24'd10066;

    // One in Q1.24, as wide as the scale factor (1 - alpha).
    localparam logic [GAIN_W:0] ONE_Q24 = 25'h1000000;

endpackage

/* hdl/adaptive_congestion_gain_update.sv */
// Adaptive congestion gain update: smoothed busy ratio and delta recurrence.
// Depends on acgu_pkg for widths, register indexes and reset values.
// m_valid rises once a valid request has passed the input register, product register and
// result register. Throughput: one request per cycle while m_ready holds; the delta
// recurrence closes through the delta register and the (1 - alpha) * delta multiplier.
// Requests with sample_valid low are accepted and dropped without a result.
// Synchronous reset (aresetn low) restores register defaults, clears valids and loop state.
`timescale 1ns / 1ps

module adaptive_congestion_gain_update (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [acgu_pkg::RATIO_W-1:0]    s_current_ratio,
    input  logic [acgu_pkg::RATIO_W-1:0]    s_previous_ratio,
    input  logic                            s_sample_valid,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [acgu_pkg::GAIN_W-1:0]     m_delta_out,
    input  logic                            cfg_wr_en,
    input  logic [acgu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acgu_pkg::CFG_DAT_W-1:0]  cfg_wr_data
);
    import acgu_pkg::*;

    // Configuration registers.
    logic [RATIO_W-1:0]       cbr_target_reg;
    logic [GAIN_W-1:0]        beta_gain_reg;
    logic [GAIN_W-1:0]        alpha_gain_reg;
    logic [GAIN_W-1:0]        gain_max_reg;
    logic signed [GMIN_W-1:0] gain_min_reg;
    logic [GAIN_W-1:0]        delta_max_reg;
    logic [GAIN_W-1:0]        delta_min_reg;

    // Recurrence state.
    logic [RATIO_W-1:0]       smoothed_reg;
    logic [RATIO_W-1:0]       smoothed_next;
    logic                     seen_reg;
    logic [GAIN_W-1:0]        delta_reg;
    logic [GAIN_W-1:0]        delta_next;

    // Pipeline registers.
    logic                     in_valid_reg;
    logic [RATIO_W-1:0]       cur_reg;
    logic [RATIO_W-1:0]       prev_reg;
    logic                     prod_valid_reg;
    logic signed [41:0]       prod_reg;
    logic signed [41:0]       prod_next;
    logic                     gap_pos_reg;
    logic                     gap_pos_next;
    logic                     out_valid_reg;
    logic [GAIN_W-1:0]        out_reg;

    // Flow control.
    logic                     out_load;
    logic                     move_prod;
    logic                     prod_load;
    logic                     move_in;
    logic                     in_load;
    logic                     s_accept;

    // Stage one arithmetic.
    logic [RATIO_W:0]         mean_sum;
    logic [RATIO_W-1:0]       mean;
    logic [RATIO_W:0]         smooth_sum;
    logic signed [RATIO_W:0]  gap;

    // Stage two arithmetic.
    logic signed [25:0]       factor;
    logic signed [25:0]       offset;
    logic [GAIN_W:0]          keep_scale;
    logic [48:0]              keep;
    logic [GAIN_W:0]          keep_hi;
    logic signed [26:0]       d_sum;
    logic signed [26:0]       d_upper;
    logic signed [26:0]       dmax_ext;
    logic signed [26:0]       dmin_ext;
    logic signed [25:0]       gmax_ext;
    logic signed [25:0]       gmin_ext;

    assign out_load  = !out_valid_reg || m_ready;
    assign move_prod = prod_valid_reg && out_load;
    assign prod_load = !prod_valid_reg || move_prod;
    assign move_in   = in_valid_reg && prod_load;
    assign in_load   = !in_valid_reg || move_in;
    assign s_ready   = in_load;
    assign s_accept  = s_valid && s_ready;

    assign m_valid     = out_valid_reg;
    assign m_delta_out = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cbr_target_reg <= CBR_TARGET_RST;
            beta_gain_reg  <= BETA_GAIN_RST;
            alpha_gain_reg <= ALPHA_GAIN_RST;
            gain_max_reg   <= GAIN_MAX_RST;
            gain_min_reg   <= GAIN_MIN_RST;
            delta_max_reg  <= DELTA_MAX_RST;
            delta_min_reg  <= DELTA_MIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_CBR_TARGET: cbr_target_reg <= cfg_wr_data[RATIO_W-1:0];
                CFG_BETA_GAIN:  beta_gain_reg  <= cfg_wr_data[GAIN_W-1:0];
                CFG_ALPHA_GAIN: alpha_gain_reg <= cfg_wr_data[GAIN_W-1:0];
                CFG_GAIN_MAX:   gain_max_reg   <= cfg_wr_data[GAIN_W-1:0];
                CFG_GAIN_MIN:   gain_min_reg   <= $signed(cfg_wr_data[GMIN_W-1:0]);
                CFG_DELTA_MAX:  delta_max_reg  <= cfg_wr_data[GAIN_W-1:0];
                CFG_DELTA_MIN:  delta_min_reg  <= cfg_wr_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage one: smoothing, gap and the beta product.
    always_comb begin
        mean_sum      = {1'b0, cur_reg} + {1'b0, prev_reg};
        mean          = mean_sum[RATIO_W:1];
        smooth_sum    = {1'b0, smoothed_reg} + {1'b0, mean};
        smoothed_next = seen_reg ? smooth_sum[RATIO_W:1] : mean;
        gap           = $signed({1'b0, cbr_target_reg}) - $signed({1'b0, smoothed_next});
        gap_pos_next  = !gap[RATIO_W] && (gap != '0);
        prod_next     = $signed({{18{1'b0}}, beta_gain_reg})
                      * $signed({{25{gap[RATIO_W]}}, gap});
    end

    // Stage two: clamped offset plus the decayed delta, then the delta bounds.
    always_comb begin
        // Arithmetic shift of the product gives the floor of the division by 2^16.
        factor     = prod_reg[41:16];
        gmax_ext   = $signed({2'b00, gain_max_reg});
        gmin_ext   = $signed({gain_min_reg[GMIN_W-1], gain_min_reg});
        if (gap_pos_reg) begin
            offset = (factor < gmax_ext) ? factor : gmax_ext;
        end else begin
            offset = (factor > gmin_ext) ? factor : gmin_ext;
        end
        keep_scale = ONE_Q24 - {1'b0, alpha_gain_reg};
        keep       = {24'b0, keep_scale} * {25'b0, delta_reg};
        keep_hi    = keep[48:24];
        d_sum      = $signed({2'b00, keep_hi}) + $signed({offset[25], offset});
        dmax_ext   = $signed({3'b000, delta_max_reg});
        dmin_ext   = $signed({3'b000, delta_min_reg});
        d_upper    = (d_sum > dmax_ext) ? dmax_ext : d_sum;
        // The lower bound wins when the two bounds cross.
        delta_next = (d_upper < dmin_ext) ? delta_min_reg : d_upper[GAIN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            smoothed_reg   <= '0;
            seen_reg       <= 1'b0;
            delta_reg      <= '0;
        end else begin
            if (in_load) begin
                in_valid_reg <= s_accept && s_sample_valid;
            end
            if (prod_load) begin
                prod_valid_reg <= move_in;
            end
            if (out_load) begin
                out_valid_reg <= move_prod;
            end
            if (move_in) begin
                smoothed_reg <= smoothed_next;
                seen_reg     <= 1'b1;
            end
            if (move_prod) begin
                delta_reg <= delta_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cur_reg  <= s_current_ratio;
            prev_reg <= s_previous_ratio;
        end
        if (move_in) begin
            prod_reg    <= prod_next;
            gap_pos_reg <= gap_pos_next;
        end
        if (move_prod) begin
            out_reg <= delta_next;
        end
    end

    // The waiting result always equals the delta held for the next request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_delta_out == delta_reg))
        else $error("result register and delta state disagree");

    // Nothing can be past the input register before the first sample was seen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !seen_reg |-> (!prod_valid_reg && !out_valid_reg))
        else $error("request in flight before the first sample");

    // The smoothing state only starts on a request that leaves the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(seen_reg) |-> $past(move_in))
        else $error("smoothing state started without a request");

    // With the result register empty the whole pipeline can advance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the result register is empty");

endmodule

/* tb/adaptive_congestion_gain_update_test.sv */
// Self-checking testbench for adaptive_congestion_gain_update: directed and random ticks
// over several register settings, checked against an in-bench model of the delta update.
// Depends on acgu_pkg and the adaptive_congestion_gain_update RTL.
`timescale 1ns / 1ps

module adaptive_congestion_gain_update_test;
    import acgu_pkg::*;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int TICKS_PER_SET  = 140;
    localparam int DRAIN_CYCLES   = 8;
    localparam int N_DIRECTED     = 20;
    localparam int MAX_REPORTS    = 10;
    // No register sits at this index; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    typedef struct packed {
        logic [RATIO_W-1:0] cur;
        logic [RATIO_W-1:0] prev;
        logic               sv;
        logic               known;
        logic [GAIN_W-1:0]  want;
    } tick_row_t;

    typedef struct packed {
        logic [RATIO_W-1:0] target;
        logic [GAIN_W-1:0]  beta;
        logic [GAIN_W-1:0]  alpha;
        logic [GAIN_W-1:0]  gmax;
        logic [GMIN_W-1:0]  gmin;
        logic [GAIN_W-1:0]  dmax;
        logic [GAIN_W-1:0]  dmin;
    } gain_set_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [RATIO_W-1:0]   s_current_ratio = '0;
    logic [RATIO_W-1:0]   s_previous_ratio = '0;
    logic                 s_sample_valid = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [GAIN_W-1:0]    m_delta_out;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wr_data = '0;

    // Fixed expectation that rides along with the request currently on the bus.
    logic                 tick_known = 1'b0;
    logic [GAIN_W-1:0]    tick_want = '0;

    // Model copy of the registers and the loop state.
    logic [RATIO_W-1:0]   reg_target = CBR_TARGET_RST;
    logic [GAIN_W-1:0]    reg_beta = BETA_GAIN_RST;
    logic [GAIN_W-1:0]    reg_alpha = ALPHA_GAIN_RST;
    logic [GAIN_W-1:0]    reg_gmax = GAIN_MAX_RST;
    logic [GMIN_W-1:0]    reg_gmin = GAIN_MIN_RST;
    logic [GAIN_W-1:0]    reg_dmax = DELTA_MAX_RST;
    logic [GAIN_W-1:0]    reg_dmin = DELTA_MIN_RST;
    logic [RATIO_W-1:0]   busy_avg = '0;
    logic                 busy_seen = 1'b0;
    logic [GAIN_W-1:0]    delta_state = '0;

    logic [GAIN_W-1:0]    delta_expected_q[$];
    int                   cycles = 0;
    int                   mismatch_count = 0;
    int                   results_checked = 0;
    int                   ticks_sent = 0;
    int                   ticks_skipped = 0;
    int                   settings_used = 0;
    int                   burst_left = 0;
    logic [15:0]          ready_phase = '0;

    tick_row_t directed_rows [0:N_DIRECTED-1] = '{
        // A skipped tick before any sample must not count as the first sample.
        '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 24'd0},
        // First sample lands on target: no offset, delta from zero rises to the floor.
        '{16'd44564, 16'd44564, 1'b1, 1'b1, DELTA_MIN_RST},
        // Busy above target gives a negative offset, so delta stays on the floor.
        '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, DELTA_MIN_RST},
        '{16'h0000, 16'h0000, 1'b1, 1'b0, 24'd0},
        '{16'h0000, 16'h0000, 1'b1, 1'b0, 24'd0},
        '{16'h0000, 16'h0000, 1'b1, 1'b0, 24'd0},
        '{16'h0000, 16'h0000, 1'b1, 1'b0, 24'd0},
        '{16'h0000, 16'hFFFF, 1'b0, 1'b0, 24'd0},
        '{16'hFFFF, 16'h0000, 1'b1, 1'b0, 24'd0},
        '{16'h0000, 16'hFFFF, 1'b1, 1'b0, 24'd0},
        '{16'h0001, 16'h0000, 1'b1, 1'b0, 24'd0},
        '{16'hFFFF, 16'hFFFE, 1'b1, 1'b0, 24'd0},
        '{16'h8000, 16'h7FFF, 1'b1, 1'b0, 24'd0},
        '{16'h0000, 16'h0001, 1'b0, 1'b0, 24'd0},
        '{16'd44564, 16'd44564, 1'b1, 1'b0, 24'd0},
        '{16'd44565, 16'd44565, 1'b1, 1'b0, 24'd0},
        '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 24'd0},
        '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 24'd0},
        '{16'hFFFF, 16'h0000, 1'b1, 1'b0, 24'd0},
        '{16'h5555, 16'hAAAA, 1'b1, 1'b0, 24'd0}
    };

    adaptive_congestion_gain_update dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_current_ratio  (s_current_ratio),
        .s_previous_ratio (s_previous_ratio),
        .s_sample_valid   (s_sample_valid),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_delta_out      (m_delta_out),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    // Update the smoothed ratio and delta for one valid tick and return the new delta.
    function automatic logic [GAIN_W-1:0] predict_delta(input logic [RATIO_W-1:0] cur,
                                                        input logic [RATIO_W-1:0] prev);
        logic [RATIO_W:0] sum;
        logic [RATIO_W-1:0] mean;
        longint gap;
        longint factor;
        longint offset;
        longint keep;
        longint d;
        longint gmin_s;
        sum = {1'b0, cur} + {1'b0, prev};
        mean = sum[RATIO_W:1];
        if (busy_seen) begin
            sum = {1'b0, busy_avg} + {1'b0, mean};
            busy_avg = sum[RATIO_W:1];
        end else begin
            busy_avg = mean;
        end
        busy_seen = 1'b1;
        gap = longint'(reg_target) - longint'(busy_avg);
        // Arithmetic shift floors the scaled product for a negative gap as well.
        factor = (longint'(reg_beta) * gap) >>> 16;
        gmin_s = longint'($signed(reg_gmin));
        if (gap > 0)
            offset = (factor < longint'(reg_gmax)) ? factor : longint'(reg_gmax);
        else
            offset = (factor > gmin_s) ? factor : gmin_s;
        keep = ((longint'(ONE_Q24) - longint'(reg_alpha)) * longint'(delta_state)) >>> 24;
        d = keep + offset;
        if (d > longint'(reg_dmax))
            d = longint'(reg_dmax);
        if (d < longint'(reg_dmin))
            d = longint'(reg_dmin);
        delta_state = d[GAIN_W-1:0];
        return delta_state;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_CBR_TARGET: reg_target = data[RATIO_W-1:0];
            CFG_BETA_GAIN:  reg_beta = data[GAIN_W-1:0];
            CFG_ALPHA_GAIN: reg_alpha = data[GAIN_W-1:0];
            CFG_GAIN_MAX:   reg_gmax = data[GAIN_W-1:0];
            CFG_GAIN_MIN:   reg_gmin = data[GMIN_W-1:0];
            CFG_DELTA_MAX:  reg_dmax = data[GAIN_W-1:0];
            CFG_DELTA_MIN:  reg_dmin = data[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic gain_set_t random_gains();
        gain_set_t g;
        g.target = RATIO_W'($urandom_range(0, 65535));
        g.beta = ($urandom_range(0, 2) == 0) ? GAIN_W'($urandom)
                                              : GAIN_W'($urandom_range(0, 24'h040000));
        g.alpha = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom)
                                               : GAIN_W'($urandom_range(0, 24'h100000));
        g.gmax = ($urandom_range(0, 2) == 0) ? GAIN_W'($urandom)
                                              : GAIN_W'($urandom_range(0, 24'h010000));
        g.gmin = 25'h0 - GMIN_W'($urandom_range(0, 24'hFFFFFF));
        g.dmax = GAIN_W'($urandom);
        g.dmin = GAIN_W'($urandom_range(0, g.dmax));
        return g;
    endfunction

    task automatic report_bad(input string what, input logic [GAIN_W-1:0] want,
                              input logic [GAIN_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, delta_expected_q.size());
            $display("FAIL adaptive_congestion_gain_update");
            $finish;
        end
    end

    // Result check comes first: a request accepted on this edge cannot return on it.
    always @(posedge aclk) begin
        logic [GAIN_W-1:0] want;
        logic [GAIN_W-1:0] predicted;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (delta_expected_q.size() == 0) begin
                    report_bad("result with nothing expected", '0, m_delta_out);
                end else begin
                    want = delta_expected_q.pop_front();
                    if (m_delta_out !== want)
                        report_bad("delta_out mismatch", want, m_delta_out);
                end
            end
            if (s_valid && s_ready && s_sample_valid) begin
                predicted = predict_delta(s_current_ratio, s_previous_ratio);
                delta_expected_q.push_back(tick_known ? tick_want : predicted);
            end
        end
    end

    // Receiver backpressure: free flow, coin flips, sparse ready, and long stalls in turn.
    always @(negedge aclk) begin
        ready_phase <= ready_phase + 1'b1;
        case (ready_phase[8:7])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (ready_phase[4:0] >= 5'd22);
        endcase
    end

    task automatic send_tick(input tick_row_t t);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_current_ratio <= t.cur;
        s_previous_ratio <= t.prev;
        s_sample_valid <= t.sv;
        tick_known <= t.known;
        tick_want <= t.want;
        do @(posedge aclk); while (!s_ready);
        if (t.sv)
            ticks_sent++;
        else
            ticks_skipped++;
    endtask

    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            s_current_ratio <= RATIO_W'($urandom);
            s_sample_valid <= 1'($urandom_range(0, 1));
        end
    endtask

    // Drop valid, let every expected result come back, then let the pipe run empty.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (delta_expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        apply_config(idx, data);
    endtask

    task automatic load_gains(input gain_set_t g);
        write_reg(CFG_CBR_TARGET, CFG_DAT_W'(g.target));
        write_reg(CFG_BETA_GAIN, CFG_DAT_W'(g.beta));
        write_reg(CFG_ALPHA_GAIN, CFG_DAT_W'(g.alpha));
        write_reg(CFG_GAIN_MAX, CFG_DAT_W'(g.gmax));
        write_reg(CFG_GAIN_MIN, g.gmin);
        write_reg(CFG_DELTA_MAX, CFG_DAT_W'(g.dmax));
        write_reg(CFG_DELTA_MIN, CFG_DAT_W'(g.dmin));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Mostly valid ticks, at random, around the target and at the extremes, with skipped ticks mixed in.
    task automatic run_random(input int n_valid);
        tick_row_t t;
        int start;
        int pick;
        int v;
        start = ticks_sent;
        while (ticks_sent - start < n_valid) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 2) != 0)
                    hold_off($urandom_range(1, 6));
            end
            burst_left--;
            t.known = 1'b0;
            t.want = '0;
            t.sv = ($urandom_range(0, 99) >= 12);
            pick = $urandom_range(0, 99);
            t.cur = RATIO_W'($urandom);
            t.prev = RATIO_W'($urandom);
            if (pick >= 30 && pick < 60) begin
                v = int'(reg_target) + int'($urandom_range(0, 2000)) - 1000;
                t.cur = (v < 0) ? 16'h0 : (v > 65535) ? 16'hFFFF : RATIO_W'(v);
                t.prev = t.cur ^ RATIO_W'($urandom_range(0, 255));
            end else if (pick >= 60 && pick < 80) begin
                t.cur = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                t.prev = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else if (pick >= 80) begin
                t.prev = '0;
            end
            send_tick(t);
        end
    endtask

    initial begin
        gain_set_t g;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        settings_used = 1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_tick(directed_rows[i]);
        run_random(TICKS_PER_SET);
        settle();

        // Every register at its top but delta_min at zero, gain_min at its most negative.
        g = '{16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 25'h1000000, 24'hFFFFFF, 24'h0};
        load_gains(g);
        run_random(TICKS_PER_SET);
        settle();

        g = '0;
        load_gains(g);
        run_random(TICKS_PER_SET);
        settle();

        // Lower bound above the upper bound: the lower bound wins.
        g = random_gains();
        g.dmax = GAIN_W'($urandom_range(0, 24'h001000));
        g.dmin = GAIN_W'($urandom_range(24'h100000, 24'hFFFFFF));
        load_gains(g);
        run_random(TICKS_PER_SET);
        settle();

        // A positive gain_min still acts as the floor on the offset.
        g = random_gains();
        g.gmin = GMIN_W'($urandom_range(1, 24'h00FFFF));
        g.dmax = 24'hFFFFFF;
        load_gains(g);
        run_random(TICKS_PER_SET);
        settle();

        // Writes to the unused index must leave the loaded settings alone.
        g = random_gains();
        load_gains(g);
        write_reg(CFG_SPARE_IDX, CFG_DAT_W'($urandom));
        write_reg(CFG_SPARE_IDX, 25'h1FFFFFF);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        run_random(TICKS_PER_SET);
        settle();

        g = random_gains();
        load_gains(g);
        run_random(TICKS_PER_SET);
        settle();

        $display("Checked %0d delta results from %0d sample ticks and %0d skipped ticks",
                 results_checked, ticks_sent, ticks_skipped);
        $display("across %0d register settings; %0d mismatches", settings_used,
                 mismatch_count);
        if (mismatch_count == 0 && delta_expected_q.size() == 0)
            $display("PASS adaptive_congestion_gain_update");
        else
            $display("FAIL adaptive_congestion_gain_update");
        $finish;
    end

endmodule

/* filelist.f */
hdl/acgu_pkg.sv
hdl/adaptive_congestion_gain_update.sv
tb/adaptive_congestion_gain_update_test.sv
